### hw/rtl/sorted_list_merge_assert.svh
// Assertion macros for the sorted list merge block.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef SORTED_LIST_MERGE_ASSERT_SVH
`define SORTED_LIST_MERGE_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define SLM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define SLM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/slm_pkg.sv
// Shared constants and types for the sorted list merge block.
// Used by the merge engine and the top level; depends on nothing.
`default_nettype none

package slm_pkg;

  localparam int LIST_DEPTH = 16;
  localparam int DATA_W     = 32;
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

  localparam logic [1:0] CMD_LOAD_A = 2'd0;
  localparam logic [1:0] CMD_LOAD_B = 2'd1;
  localparam logic [1:0] CMD_MERGE  = 2'd2;

  typedef struct packed {
    logic             go;
    logic [CNT_W-1:0] cnt_a;
    logic [CNT_W-1:0] cnt_b;
  } merge_start_t;

endpackage

`default_nettype wire

### hw/rtl/slm_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Stands alone; width and depth are set by the instantiating module.
`default_nettype none

module slm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hw/rtl/slm_merge.sv
// Merge engine: walks both list memories with two read pointers and emits
// the merged run through an output register. Depends on slm_pkg.
`default_nettype none

module slm_merge (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire slm_pkg::merge_start_t       start,
  input  wire logic [slm_pkg::DATA_W-1:0]  rdata_a,
  input  wire logic [slm_pkg::DATA_W-1:0]  rdata_b,
  output logic      [slm_pkg::IDX_W-1:0]   raddr_a,
  output logic      [slm_pkg::IDX_W-1:0]   raddr_b,
  output logic                             busy,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic      [slm_pkg::DATA_W-1:0]  out_merged_value,
  output logic                             out_last
);

  logic                       busy_r, busy_nxt;
  logic [slm_pkg::CNT_W-1:0]  ia_r, ia_nxt, ib_r, ib_nxt;
  logic [slm_pkg::CNT_W-1:0]  na_r, na_nxt, nb_r, nb_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [slm_pkg::DATA_W-1:0] out_value_r, out_value_nxt;
  logic                       out_last_r, out_last_nxt;
  logic                       has_a, has_b, take_a, advance, done;

  always_comb begin
    has_a   = ia_r < na_r;
    has_b   = ib_r < nb_r;
    take_a  = has_a && (!has_b || ($signed(rdata_a) < $signed(rdata_b)));
    advance = busy_r && (!out_valid_r || !out_stall);

    ia_nxt = ia_r;
    ib_nxt = ib_r;
    na_nxt = na_r;
    nb_nxt = nb_r;
    if (start.go) begin
      ia_nxt = '0;
      ib_nxt = '0;
      na_nxt = start.cnt_a;
      nb_nxt = start.cnt_b;
    end else if (advance) begin
      if (take_a) begin
        ia_nxt = ia_r + slm_pkg::CNT_W'(1);
      end else begin
        ib_nxt = ib_r + slm_pkg::CNT_W'(1);
      end
    end
    done = (ia_nxt == na_r) && (ib_nxt == nb_r);

    busy_nxt = busy_r;
    if (start.go) begin
      busy_nxt = 1'b1;
    end else if (advance && done) begin
      busy_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
      out_value_nxt = take_a ? rdata_a : rdata_b;
      out_last_nxt  = done;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      ia_r        <= '0;
      ib_r        <= '0;
      na_r        <= '0;
      nb_r        <= '0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      ia_r        <= ia_nxt;
      ib_r        <= ib_nxt;
      na_r        <= na_nxt;
      nb_r        <= nb_nxt;
    end
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign raddr_a          = ia_nxt[slm_pkg::IDX_W-1:0];
  assign raddr_b          = ib_nxt[slm_pkg::IDX_W-1:0];
  assign busy             = busy_r;
  assign out_valid        = out_valid_r;
  assign out_merged_value = out_value_r;
  assign out_last         = out_last_r;

endmodule

`default_nettype wire

### hw/rtl/sorted_list_merge.sv
// Top level of the sorted list merge block: load handling, list counts,
// the two list memories and the merge engine. Depends on slm_pkg,
// slm_ram, slm_merge and sorted_list_merge_assert.svh.
//
//   Channel   Direction  Ports                              Handshake
//   in        input      in_command, in_value               in_valid / in_stall
//   out       output     out_merged_value, out_last         out_valid / out_stall
//
// Loads may arrive back to back.
// A merge beat with n stored values emits them one value per cycle while the output is not stalled.
// Input is stalled while a merge runs; output stalls pause the merge.
// Reset empties both lists; memory contents are not cleared.
`default_nettype none
`include "sorted_list_merge_assert.svh"

module sorted_list_merge (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [1:0]                  in_command,
  input  wire logic [slm_pkg::DATA_W-1:0]  in_value,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic      [slm_pkg::DATA_W-1:0]  out_merged_value,
  output logic                             out_last
);

  logic [slm_pkg::CNT_W-1:0]  count_a_r, count_a_nxt, count_b_r, count_b_nxt;
  logic                       in_acc, we_a, we_b, busy;
  slm_pkg::merge_start_t      start;
  logic [slm_pkg::IDX_W-1:0]  raddr_a, raddr_b;
  logic [slm_pkg::DATA_W-1:0] rdata_a, rdata_b;

  always_comb begin
    in_acc = in_valid && !in_stall;
    we_a   = in_acc && (in_command == slm_pkg::CMD_LOAD_A) &&
             (count_a_r < slm_pkg::CNT_W'(slm_pkg::LIST_DEPTH));
    we_b   = in_acc && (in_command == slm_pkg::CMD_LOAD_B) &&
             (count_b_r < slm_pkg::CNT_W'(slm_pkg::LIST_DEPTH));

    start.go    = in_acc && (in_command == slm_pkg::CMD_MERGE) &&
                  ((count_a_r != '0) || (count_b_r != '0));
    start.cnt_a = count_a_r;
    start.cnt_b = count_b_r;

    count_a_nxt = count_a_r;
    count_b_nxt = count_b_r;
    if (start.go) begin
      count_a_nxt = '0;
      count_b_nxt = '0;
    end else begin
      if (we_a) begin
        count_a_nxt = count_a_r + slm_pkg::CNT_W'(1);
      end
      if (we_b) begin
        count_b_nxt = count_b_r + slm_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_a_r <= '0;
      count_b_r <= '0;
    end else begin
      count_a_r <= count_a_nxt;
      count_b_r <= count_b_nxt;
    end
  end

  assign in_stall = busy;

  slm_ram #(
    .WIDTH (slm_pkg::DATA_W),
    .DEPTH (slm_pkg::LIST_DEPTH)
  ) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (count_a_r[slm_pkg::IDX_W-1:0]),
    .wdata (in_value),
    .raddr (raddr_a),
    .rdata (rdata_a)
  );

  slm_ram #(
    .WIDTH (slm_pkg::DATA_W),
    .DEPTH (slm_pkg::LIST_DEPTH)
  ) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (count_b_r[slm_pkg::IDX_W-1:0]),
    .wdata (in_value),
    .raddr (raddr_b),
    .rdata (rdata_b)
  );

  slm_merge u_merge (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .rdata_a          (rdata_a),
    .rdata_b          (rdata_b),
    .raddr_a          (raddr_a),
    .raddr_b          (raddr_b),
    .busy             (busy),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_merged_value (out_merged_value),
    .out_last         (out_last)
  );

  `SLM_ASSERT_SAME(a_count_a_bound, 1'b1, count_a_r <= slm_pkg::CNT_W'(slm_pkg::LIST_DEPTH), "list A count above depth")
  `SLM_ASSERT_SAME(a_lists_empty_in_merge, busy, (count_a_r == '0) && (count_b_r == '0), "lists not empty during merge")
  `SLM_ASSERT_NEXT(a_stall_holds, out_valid && out_stall, out_valid && $stable(out_merged_value) && $stable(out_last), "stalled result beat changed")
  `SLM_ASSERT_NEXT(a_start_runs, start.go, busy, "merge did not start")

endmodule

`default_nettype wire
